// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ESC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/esc_pkg.sv =====
`timescale 1ns / 1ps
// Constants, types and small tables of the epoch-to-calendar converter
package esc_pkg;

	localparam int unsigned SecPerMin  = 60;
	localparam int unsigned SecPerHour = 3600;
	localparam int unsigned SecPerDay  = 86400;
	localparam int unsigned DaysPerWeek = 7;

	// Reciprocal divides: q = (x * Recip) >> Shift, then one correction step.
	// Valid while x < 2**Shift, so the estimate is low by at most one.
	localparam int unsigned     DayShift  = 31;
	localparam longint unsigned DayRecip  = (64'd1 << DayShift) / 64'(SecPerDay);
	localparam int unsigned     HourShift = 17;
	localparam int unsigned     HourRecip = (1 << HourShift) / SecPerHour;
	localparam int unsigned     MinShift  = 12;
	localparam int unsigned     MinRecip  = (1 << MinShift) / SecPerMin;
	localparam int unsigned     WeekShift = 15;
	localparam int unsigned     WeekRecip = (1 << WeekShift) / DaysPerWeek;

	// Julian-day style date conversion
	localparam int unsigned JdaBias    = 102032;
	localparam int unsigned JdaCycle   = 146097;
	localparam int unsigned JdOffset   = 2442113;
	localparam int unsigned YearBias   = 2442;
	localparam int unsigned YearDiv    = 7305;
	localparam int unsigned YearShift  = 26;
	localparam int unsigned YearRecip  = (1 << YearShift) / YearDiv;
	localparam int unsigned MonthDiv   = 30601;
	localparam int unsigned MonthMul   = 1000;
	localparam int unsigned MonthShift = 19;
	localparam int unsigned MonthRecip = (1 << MonthShift) / MonthDiv;
	localparam int unsigned MonthScale = MonthMul * MonthRecip;
	localparam int unsigned EraEarly   = 4716;
	localparam int unsigned EraLate    = 4715;
	localparam int unsigned YearBase   = 1900;
	localparam int unsigned LastEarlyMonth = 13;

	// Epoch day zero is a Thursday
	localparam int unsigned EpochWeekOffset = 3;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	// floor(601 * e / 1000) for the month index e
	function automatic logic [3:0] frac601(input logic [3:0] e);
		logic [3:0] r;
		case (e)
			4'd0, 4'd1:   r = 4'd0;
			4'd2, 4'd3:   r = 4'd1;
			4'd4:         r = 4'd2;
			4'd5, 4'd6:   r = 4'd3;
			4'd7, 4'd8:   r = 4'd4;
			4'd9:         r = 4'd5;
			4'd10, 4'd11: r = 4'd6;
			4'd12, 4'd13: r = 4'd7;
			4'd14:        r = 4'd8;
			default:      r = 4'd9;
		endcase
		return r;
	endfunction

	// Days in the months before month m of a common year
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/esc_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the epoch-to-calendar converter
interface esc_epoch_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_cal_if;
	logic       valid;
	logic       ready;
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [7:0] year_since_1900;
	logic [3:0] month_index;
	logic [4:0] day_of_month;
	logic [2:0] weekday;
	logic [8:0] day_of_year;

	modport source (
		output valid, output second, output minute, output hour,
		output year_since_1900, output month_index, output day_of_month,
		output weekday, output day_of_year, input ready
	);
	modport sink (
		input valid, input second, input minute, input hour,
		input year_since_1900, input month_index, input day_of_month,
		input weekday, input day_of_year, output ready
	);
endinterface

// ===== sv/esc_tod.sv =====
`timescale 1ns / 1ps
// Time-of-day split of the seconds within a day, stages 3 to 10
module esc_tod (
	input  logic          clk,
	input  logic          en,
	input  logic [16:0]   sod,
	output esc_pkg::tod_t tod
);
	logic [22:0] hq_prod;
	logic [16:0] h_rem;
	logic        h_fix;
	logic [18:0] mq_prod;
	logic [11:0] m_rem;
	logic        m_fix;

	logic [16:0]   sod_s3;
	logic [4:0]    hq_s3;
	logic [11:0]   soh_s4;
	logic [4:0]    hour_s4;
	logic [11:0]   soh_s5;
	logic [4:0]    hour_s5;
	logic [5:0]    mq_s5;
	esc_pkg::tod_t tod_s6;
	esc_pkg::tod_t tod_s7;
	esc_pkg::tod_t tod_s8;
	esc_pkg::tod_t tod_s9;
	esc_pkg::tod_t tod_s10;

	assign hq_prod = 23'(sod) * 23'(esc_pkg::HourRecip);
	assign h_rem   = sod_s3 - 17'(hq_s3) * 17'(esc_pkg::SecPerHour);
	assign h_fix   = h_rem >= 17'(esc_pkg::SecPerHour);
	assign mq_prod = 19'(soh_s4) * 19'(esc_pkg::MinRecip);
	assign m_rem   = soh_s5 - 12'(mq_s5) * 12'(esc_pkg::SecPerMin);
	assign m_fix   = m_rem >= 12'(esc_pkg::SecPerMin);

	always_ff @(posedge clk) begin
		if (en) begin
			sod_s3  <= sod;
			hq_s3   <= hq_prod[esc_pkg::HourShift +: 5];
			hour_s4 <= hq_s3 + 5'(h_fix);
			soh_s4  <= 12'(h_fix ? h_rem - 17'(esc_pkg::SecPerHour) : h_rem);
			soh_s5  <= soh_s4;
			hour_s5 <= hour_s4;
			mq_s5   <= mq_prod[esc_pkg::MinShift +: 6];
			tod_s6.hour   <= hour_s5;
			tod_s6.minute <= mq_s5 + 6'(m_fix);
			tod_s6.second <= 6'(m_fix ? m_rem - 12'(esc_pkg::SecPerMin) : m_rem);
			tod_s7  <= tod_s6;
			tod_s8  <= tod_s7;
			tod_s9  <= tod_s8;
			tod_s10 <= tod_s9;
		end
	end

	assign tod = tod_s10;
endmodule

// ===== sv/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// Top level: pipelined conversion of epoch seconds to a UTC calendar date and time
//
//   channel    role    payload
//   epoch      sink    epoch_seconds (signed 32)
//   calendar   source  second, minute, hour, year_since_1900, month_index,
//                      day_of_month, weekday, day_of_year
//
// One transfer in per cycle while the output is not stalled; the ten register stages
// follow the date conversion's chain of reciprocal divides and corrections.
// Reset clears the stage valid bits only; data registers keep whatever they hold.
// When the last stage holds a result the sink does not take, every stage holds
// and epoch.ready drops in the same cycle, so nothing is lost or repeated.
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
	input  logic      clk,
	input  logic      arst_n,
	esc_epoch_if.sink epoch,
	esc_cal_if.source calendar
);
	// Stage enable: advance unless a finished result is stuck at the output.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [9:0] vld_all;

	assign en          = !v_s10 || calendar.ready;
	assign epoch.ready = en;
	assign vld_all     = {v_s10, v_s9, v_s8, v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= epoch.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Stage 1: clamp negative counts to zero, estimate the day count.
	logic [30:0] t_in;
	logic [45:0] dq_prod;
	logic [30:0] t_s1;
	logic [14:0] dq_s1;

	assign t_in    = epoch.epoch_seconds[31] ? 31'd0 : epoch.epoch_seconds[30:0];
	assign dq_prod = 46'(t_in) * 46'(esc_pkg::DayRecip);

	// Stage 2: correct the day count, keep the seconds within the day.
	logic [31:0] day_rem;
	logic        day_fix;
	logic [14:0] days_s2;
	logic [16:0] sod_s2;

	assign day_rem = 32'(t_s1) - 32'(dq_s1) * 32'(esc_pkg::SecPerDay);
	assign day_fix = day_rem >= 32'(esc_pkg::SecPerDay);

	// Stage 3: shift the day count onto the Julian-style scale, estimate weekday.
	logic [17:0] a_num;
	logic [4:0]  a_val;
	logic [21:0] b_val;
	logic [25:0] x_val;
	logic [14:0] wx;
	logic [27:0] wq_prod;
	logic [21:0] b_s3;
	logic [25:0] x_s3;
	logic [14:0] wx_s3;
	logic [11:0] wq_s3;

	assign a_num   = {1'b0, days_s2, 2'b00} + 18'(esc_pkg::JdaBias);
	assign a_val   = 5'd15 + 5'(a_num >= 18'(esc_pkg::JdaCycle));
	assign b_val   = 22'(days_s2) + 22'(esc_pkg::JdOffset) + 22'(a_val) - 22'(a_val >> 2);
	assign x_val   = 26'(b_val) * 26'd20 - 26'(esc_pkg::YearBias);
	assign wx      = days_s2 + 15'(esc_pkg::EpochWeekOffset);
	assign wq_prod = 28'(wx) * 28'(esc_pkg::WeekRecip);

	// Stage 4: finish the weekday, estimate the Julian-style year.
	logic [14:0] wk_rem;
	logic [14:0] wk_day;
	logic [39:0] cq_prod;
	logic [21:0] b_s4;
	logic [25:0] x_s4;
	logic [12:0] cq_s4;
	logic [2:0]  weekday_s4;

	assign wk_rem  = wx_s3 - 15'(wq_s3) * 15'(esc_pkg::DaysPerWeek);
	assign wk_day  = (wk_rem >= 15'(esc_pkg::DaysPerWeek)) ?
		wk_rem - 15'(esc_pkg::DaysPerWeek) : wk_rem;
	assign cq_prod = 40'(x_s3) * 40'(esc_pkg::YearRecip);

	// Stage 5: correct the year estimate.
	logic [25:0] c_rem;
	logic [21:0] b_s5;
	logic [12:0] c_s5;
	logic [2:0]  weekday_s5;

	assign c_rem = x_s4 - 26'(cq_s4) * 26'(esc_pkg::YearDiv);

	// Stage 6: day within the March-based year.
	logic [21:0] d_full;
	logic [9:0]  d_s6;
	logic [12:0] c_s6;
	logic [2:0]  weekday_s6;

	assign d_full = b_s5 - 22'(c_s5) * 22'd365 - 22'(c_s5 >> 2);

	// Stage 7: estimate the month number.
	logic [24:0] eq_prod;
	logic [9:0]  d_s7;
	logic [3:0]  eq_s7;
	logic [12:0] c_s7;
	logic [2:0]  weekday_s7;

	assign eq_prod = 25'(d_s6) * 25'(esc_pkg::MonthScale);

	// Stage 8: correct the month number.
	logic [19:0] e_rem;
	logic [9:0]  d_s8;
	logic [3:0]  e_s8;
	logic [12:0] c_s8;
	logic [2:0]  weekday_s8;

	assign e_rem = 20'(d_s7) * 20'(esc_pkg::MonthMul) - 20'(eq_s7) * 20'(esc_pkg::MonthDiv);

	// Stage 9: day of month, month index and year; January and February
	// belong to the following calendar year.
	logic [9:0]  f_val;
	logic        early;
	logic [12:0] ys_full;
	logic [4:0]  day_s9;
	logic [3:0]  mon_s9;
	logic [7:0]  ys_s9;
	logic [2:0]  weekday_s9;

	assign f_val   = d_s8 - 10'(e_s8) * 10'd30 - 10'(esc_pkg::frac601(e_s8));
	assign early   = e_s8 <= 4'(esc_pkg::LastEarlyMonth);
	assign ys_full = early ? c_s8 - 13'(esc_pkg::EraEarly + esc_pkg::YearBase)
	                       : c_s8 - 13'(esc_pkg::EraLate + esc_pkg::YearBase);

	// Stage 10: day of year. Over the reachable years (1970 to 2038) the full
	// leap rule reduces to a multiple of four, 2000 included.
	logic        leap;
	logic [4:0]  day_s10;
	logic [3:0]  mon_s10;
	logic [7:0]  ys_s10;
	logic [2:0]  weekday_s10;
	logic [8:0]  doy_s10;

	assign leap = ys_s9[1:0] == 2'b00;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1        <= t_in;
			dq_s1       <= dq_prod[esc_pkg::DayShift +: 15];

			days_s2     <= dq_s1 + 15'(day_fix);
			sod_s2      <= 17'(day_fix ? day_rem - 32'(esc_pkg::SecPerDay) : day_rem);

			b_s3        <= b_val;
			x_s3        <= x_val;
			wx_s3       <= wx;
			wq_s3       <= wq_prod[esc_pkg::WeekShift +: 12];

			b_s4        <= b_s3;
			x_s4        <= x_s3;
			cq_s4       <= cq_prod[esc_pkg::YearShift +: 13];
			weekday_s4  <= 3'(wk_day) + 3'd1;

			b_s5        <= b_s4;
			c_s5        <= cq_s4 + 13'(c_rem >= 26'(esc_pkg::YearDiv));
			weekday_s5  <= weekday_s4;

			d_s6        <= d_full[9:0];
			c_s6        <= c_s5;
			weekday_s6  <= weekday_s5;

			d_s7        <= d_s6;
			eq_s7       <= eq_prod[esc_pkg::MonthShift +: 4];
			c_s7        <= c_s6;
			weekday_s7  <= weekday_s6;

			d_s8        <= d_s7;
			e_s8        <= eq_s7 + 4'(e_rem >= 20'(esc_pkg::MonthDiv));
			c_s8        <= c_s7;
			weekday_s8  <= weekday_s7;

			day_s9      <= f_val[4:0];
			mon_s9      <= early ? e_s8 - 4'd2 : e_s8 - 4'd14;
			ys_s9       <= ys_full[7:0];
			weekday_s9  <= weekday_s8;

			day_s10     <= day_s9;
			mon_s10     <= mon_s9;
			ys_s10      <= ys_s9;
			weekday_s10 <= weekday_s9;
			doy_s10     <= 9'(day_s9) + esc_pkg::days_before_month(mon_s9)
			               + 9'(leap && mon_s9 >= 4'd2);
		end
	end

	// Hours, minutes and seconds run beside the date, aligned to stage 10.
	esc_pkg::tod_t tod;

	esc_tod u_tod (
		.clk (clk),
		.en  (en),
		.sod (sod_s2),
		.tod (tod)
	);

	// Drive the result channel straight from the last stage.
	assign calendar.valid           = v_s10;
	assign calendar.second          = tod.second;
	assign calendar.minute          = tod.minute;
	assign calendar.hour            = tod.hour;
	assign calendar.year_since_1900 = ys_s10;
	assign calendar.month_index     = mon_s10;
	assign calendar.day_of_month    = day_s10;
	assign calendar.weekday         = weekday_s10;
	assign calendar.day_of_year     = doy_s10;

	`ESC_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !en, $stable(vld_all), "stages moved in a stall")
	`ESC_ASSERT_SAME(a_fields_in_range, clk, arst_n, calendar.valid, calendar.month_index <= 4'd11 && calendar.day_of_month != 5'd0 && calendar.weekday != 3'd0 && calendar.hour <= 5'd23, "result field out of range")
	`ESC_ASSERT_SAME(a_january_ordinal, clk, arst_n, calendar.valid && calendar.month_index == 4'd0, calendar.day_of_year == 9'(calendar.day_of_month), "January day of year mismatch")
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of the epoch-seconds to UTC calendar converter: directed and random timestamps against a predictor
module testbench;

	// Timing of the run
	localparam int unsigned ClkHalf      = 10;
	localparam int unsigned ResetCycles  = 10;
	localparam int unsigned RandomCount  = 1780;
	localparam int unsigned MaxGap       = 19;
	localparam int unsigned SettleCycles = 30;
	localparam int unsigned CycleLimit   = 400000;
	// The receiver holds off this long once it has taken these many results
	localparam int unsigned HoldCycles   = 400;
	localparam int unsigned HoldAtFirst  = 300;
	localparam int unsigned HoldAtSecond = 1200;
	// Last timestamp before the sign bit, and the first second of its day
	localparam int unsigned LastDayStart = 2147472000;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [7:0] year_since_1900;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
		logic [2:0] weekday;
		logic [8:0] day_of_year;
	} civil_time_t;

	typedef struct packed {
		logic signed [31:0] epoch;
		civil_time_t        civil;
	} pending_civil_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Input side, driven here and mirrored onto the channel
	logic               src_valid = 1'b0;
	logic signed [31:0] src_epoch = '0;
	int unsigned        src_gap   = 0;
	bit                 src_quiet = 1'b0;

	// Output side
	logic               snk_ready = 1'b0;
	int unsigned        snk_stall = 0;
	bit                 snk_quiet = 1'b0;

	logic signed [31:0] timestamp_queue [$];
	pending_civil_t     civil_expected [$];

	int unsigned errors        = 0;
	int unsigned results_seen  = 0;
	int unsigned clamped_count = 0;
	int unsigned input_stalls  = 0;
	int unsigned holds_done    = 0;

	esc_epoch_if epoch_ch ();
	esc_cal_if   cal_ch ();

	assign epoch_ch.valid         = src_valid;
	assign epoch_ch.epoch_seconds = src_epoch;
	assign cal_ch.ready           = snk_ready;

	epoch_seconds_to_calendar dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch    (epoch_ch),
		.calendar (cal_ch)
	);

	always #(ClkHalf) clk = ~clk;

	// Idle length before the next transfer; zero through quiet stretches
	function automatic int unsigned pick_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, MaxGap);
	endfunction

	// Broken-down UTC time for a timestamp, in 32-bit unsigned arithmetic throughout
	function automatic civil_time_t civil_from_epoch(input logic signed [31:0] secs);
		bit [31:0]   t, a, b, c, d, e, f;
		bit [31:0]   zyear, zmon, cent, yoc, h, doy;
		int unsigned mlen [12];
		bit          leap;
		civil_time_t r;
		mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		// Clamp negative counts to the epoch itself
		t = secs[31] ? 32'd0 : 32'(secs);
		r.second = 6'(t % 60);
		t = t / 60;
		r.minute = 6'(t % 60);
		t = t / 60;
		r.hour = 5'(t % 24);
		t = t / 24;
		// Day count to year, month, day
		a = (4 * t + 102032) / 146097 + 15;
		b = t + 2442113 + a - a / 4;
		c = (20 * b - 2442) / 7305;
		d = b - 365 * c - c / 4;
		e = (d * 1000) / 30601;
		f = d - e * 30 - (e * 601) / 1000;
		if (e <= 13) begin
			c = c - 4716;
			e = e - 1;
		end else begin
			c = c - 4715;
			e = e - 13;
		end
		r.year_since_1900 = 8'(c - 1900);
		r.month_index     = 4'(e - 1);
		r.day_of_month    = 5'(f);
		// Zeller on the full year; January and February count with the year before
		zyear = c;
		zmon  = e;
		if (zmon <= 2) begin
			zmon  = zmon + 12;
			zyear = zyear - 1;
		end
		cent = zyear / 100;
		yoc  = zyear % 100;
		h = f + (26 * (zmon + 1)) / 10 + yoc + yoc / 4 + 5 * cent + cent / 4;
		r.weekday = 3'((h + 5) % 7 + 1);
		// Ordinal day, leap test on the full year
		leap = ((c % 4) == 0 && (c % 100) != 0) || ((c % 400) == 0);
		doy  = f;
		for (int i = 0; i < e - 1 && i < 12; i++) begin
			doy = doy + mlen[i];
			if (i == 1 && leap)
				doy = doy + 1;
		end
		r.day_of_year = 9'(doy);
		return r;
	endfunction

	// Compare one result with its expectation field by field
	task automatic check_civil(input pending_civil_t want, input civil_time_t got);
		string       fname;
		int unsigned wv, gv;
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: begin fname = "second";          wv = want.civil.second;          gv = got.second;          end
				1: begin fname = "minute";          wv = want.civil.minute;          gv = got.minute;          end
				2: begin fname = "hour";            wv = want.civil.hour;            gv = got.hour;            end
				3: begin fname = "year_since_1900"; wv = want.civil.year_since_1900; gv = got.year_since_1900; end
				4: begin fname = "month_index";     wv = want.civil.month_index;     gv = got.month_index;     end
				5: begin fname = "day_of_month";    wv = want.civil.day_of_month;    gv = got.day_of_month;    end
				6: begin fname = "weekday";         wv = want.civil.weekday;         gv = got.weekday;         end
				default: begin fname = "day_of_year"; wv = want.civil.day_of_year;   gv = got.day_of_year;     end
			endcase
			if (wv != gv) begin
				errors++;
				$display("%0t: epoch %0d: %s expected %0d, actual %0d",
					$time, want.epoch, fname, wv, gv);
			end
		end
	endtask

	// Driver: present the next timestamp after its drawn gap, hold it until the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap   <= 0;
		end else begin
			if (src_valid && epoch_ch.ready) begin
				// Predict at the transfer itself, so the store stays in input order
				civil_expected.push_back('{epoch: src_epoch, civil: civil_from_epoch(src_epoch)});
				if (src_epoch < 0)
					clamped_count++;
			end
			if (src_valid && !epoch_ch.ready) begin
				// Hold the offered timestamp; count the back-pressure
				input_stalls++;
			end else if (src_gap != 0) begin
				src_valid <= 1'b0;
				src_gap   <= src_gap - 1;
			end else if (timestamp_queue.size() != 0) begin
				src_valid <= 1'b1;
				src_epoch <= timestamp_queue.pop_front();
				src_gap   <= pick_gap(src_quiet);
				// Switch now and then between idling and back-to-back stretches
				if ($urandom_range(0, 49) == 0)
					src_quiet <= ~src_quiet;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Monitor: take results, check them, and stall the output at random
	always @(posedge clk or negedge arst_n) begin : monitor
		int unsigned stall_draw;
		if (!arst_n) begin
			snk_ready <= 1'b0;
			snk_stall <= 0;
		end else begin
			if (cal_ch.valid && snk_ready) begin
				if (civil_expected.size() == 0) begin
					errors++;
					$display("%0t: result %0d/%0d/%0d %0d:%0d:%0d with nothing expected",
						$time, cal_ch.year_since_1900, cal_ch.month_index,
						cal_ch.day_of_month, cal_ch.hour, cal_ch.minute, cal_ch.second);
				end else begin
					check_civil(civil_expected.pop_front(), '{
						second:          cal_ch.second,
						minute:          cal_ch.minute,
						hour:            cal_ch.hour,
						year_since_1900: cal_ch.year_since_1900,
						month_index:     cal_ch.month_index,
						day_of_month:    cal_ch.day_of_month,
						weekday:         cal_ch.weekday,
						day_of_year:     cal_ch.day_of_year});
				end
				results_seen++;
				// Twice in the run hold off long enough for the pipeline to fill
				if (results_seen == HoldAtFirst || results_seen == HoldAtSecond) begin
					stall_draw = HoldCycles;
					holds_done++;
				end else begin
					stall_draw = pick_gap(snk_quiet);
				end
				if ($urandom_range(0, 49) == 0)
					snk_quiet <= ~snk_quiet;
				if (stall_draw == 0) begin
					snk_ready <= 1'b1;
				end else begin
					snk_ready <= 1'b0;
					snk_stall <= stall_draw - 1;
				end
			end else if (snk_stall != 0) begin
				snk_ready <= 1'b0;
				snk_stall <= snk_stall - 1;
			end else begin
				snk_ready <= 1'b1;
			end
		end
	end

	// Timeout: end the run if it takes far longer than the slowest correct run
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		logic signed [31:0] directed [22];
		int unsigned        pick, day, year, tod;
		longint             stamp;
		// Zero, the sign extremes, field rollovers, leap days around 1972 and 2000,
		// year ends, and the last representable day
		directed = '{0, 1, -1, int'(32'h8000_0000), int'(32'h7FFF_FFFF),
			59, 60, 3599, 3600, 86399, 86400,
			68169600, 94694399, 946684799, 946684800, 951782400, 951868800,
			978307199, 983404799, 983404800, 1234567890, int'(LastDayStart)};
		foreach (directed[i])
			timestamp_queue.push_back(directed[i]);

		for (int n = 0; n < RandomCount; n++) begin
			pick = $urandom_range(0, 7);
			if (pick <= 1) begin
				// Any 32-bit pattern; about half come out negative and clamp
				stamp = int'($urandom());
			end else if (pick <= 4) begin
				// Anywhere in the valid range
				stamp = $urandom() & 32'h7FFF_FFFF;
			end else if (pick <= 6) begin
				// Near the start or end of a random day, or anywhere within it
				day = $urandom_range(0, 24855);
				case ($urandom_range(0, 2))
					0:       tod = $urandom_range(0, 2);
					1:       tod = 86399 - $urandom_range(0, 2);
					default: tod = $urandom_range(0, 86399);
				endcase
				stamp = longint'(day) * 86400 + tod;
			end else begin
				// Around New Year of a random year
				year  = $urandom_range(1971, 2038);
				day   = 365 * (year - 1970) + (year - 1969) / 4;
				stamp = longint'(day) * 86400 + $urandom_range(0, 3) - 2;
			end
			if (stamp > 64'sh7FFF_FFFF)
				stamp = 64'sh7FFF_FFFF;
			timestamp_queue.push_back(stamp[31:0]);
		end

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for a result for every timestamp, then let the pipeline settle
		while (results_seen < $size(directed) + RandomCount)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		$display("Converted %0d timestamps (%0d directed, %0d negative and clamped)",
			results_seen, $size(directed), clamped_count);
		$display("Output hold-offs: %0d, input cycles stalled by back-pressure: %0d",
			holds_done, input_stalls);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
